// ----- rtl/rsq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsq_pkg;

  // Input command codes, carried on the slave-side tuser
  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_VERDICT = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  // Event codes, carried on the master-side tuser
  typedef enum logic [2:0] {
    EV_ACCEPTED     = 3'd0,
    EV_REJECTED     = 3'd1,
    EV_WRITTEN      = 3'd2,
    EV_COMPLETED    = 3'd3,
    EV_WRITE_FAILED = 3'd4,
    EV_TIMED_OUT    = 3'd5,
    EV_RESP_ERROR   = 3'd6
  } event_e;

  // Response verdict codes
  localparam logic [1:0] DS_COMPLETE = 2'd1;
  localparam logic [1:0] DS_ERROR    = 2'd2;

  // Configuration register index (paddr[2])
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [31:0] uid;
    logic [1:0]  kind;
    logic        expects;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic   latch_in;
    logic   push;
    logic   rd_head;
    logic   pop;
    logic   clr_wait;
    logic   flush;
    logic   emit;
    event_e emit_kind;
    logic   emit_cur;
    logic   emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] ds;
    logic       wok;
    logic       full;
    logic       empty;
    logic       waiting;
    logic       due;
    logic       head_exp;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rsq_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsq_dp #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      cmd_i,
  input  wire logic [31:0]     now_i,
  input  wire logic [31:0]     uid_i,
  input  wire logic [1:0]      kind_i,
  input  wire logic            exp_i,
  input  wire logic            wok_i,
  input  wire logic [1:0]      ds_i,
  input  wire logic [7:0]      timeout_i,
  input  wire rsq_pkg::dp_cmd_t ctl_i,
  output rsq_pkg::dp_sts_t     sts_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           out_kind_o,
  output logic [31:0]          out_uid_o,
  output logic [1:0]           out_req_kind_o,
  output logic                 out_last_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Latched input item
  logic [1:0]  cmd_q;
  logic [31:0] now_q;
  logic [31:0] uid_q;
  logic [1:0]  kind_q;
  logic        exp_q;
  logic        wok_q;
  logic [1:0]  ds_q;

  // Queue and in-flight state
  rsq_pkg::entry_t mem [QUEUE_DEPTH];
  rsq_pkg::entry_t rd_q;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW:0]     tail_sum;
  logic [AW-1:0]   tail;
  logic            waiting_q, waiting_d;
  logic [31:0]     cur_uid_q;
  logic [1:0]      cur_kind_q;
  logic [32:0]     deadline_q;

  // Output register
  logic        ovalid_q;
  logic [2:0]  okind_q;
  logic [31:0] ouid_q;
  logic [1:0]  oreq_q;
  logic        olast_q;

  logic out_free;
  logic full;
  logic empty;

  assign full     = (count_q == CW'(QUEUE_DEPTH));
  assign empty    = (count_q == '0);
  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
    if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      cmd_q  <= cmd_i;
      now_q  <= now_i;
      uid_q  <= uid_i;
      kind_q <= kind_i;
      exp_q  <= exp_i;
      wok_q  <= wok_i;
      ds_q   <= ds_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail] <= '{uid: uid_q, kind: kind_q, expects: exp_q};
    end
    if (ctl_i.rd_head) begin
      rd_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    waiting_d = waiting_q;
    if (ctl_i.flush) begin
      head_d    = '0;
      count_d   = '0;
      waiting_d = 1'b0;
    end else begin
      if (ctl_i.push) begin
        count_d = count_q + CW'(1);
      end
      if (ctl_i.clr_wait) begin
        waiting_d = 1'b0;
      end
      if (ctl_i.pop) begin
        head_d    = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d   = count_q - CW'(1);
        waiting_d = rd_q.expects && wok_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      waiting_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      waiting_q <= waiting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop) begin
      cur_uid_q  <= rd_q.uid;
      cur_kind_q <= rd_q.kind;
      if (rd_q.expects) begin
        deadline_q <= {1'b0, now_q} + {25'b0, timeout_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      okind_q <= ctl_i.emit_kind;
      ouid_q  <= ctl_i.emit_cur ? cur_uid_q : uid_q;
      oreq_q  <= ctl_i.emit_cur ? cur_kind_q : kind_q;
      olast_q <= ctl_i.emit_last;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign out_kind_o     = okind_q;
  assign out_uid_o      = ouid_q;
  assign out_req_kind_o = oreq_q;
  assign out_last_o     = olast_q;

  always_comb begin
    sts_o.cmd      = rsq_pkg::cmd_e'(cmd_q);
    sts_o.ds       = ds_q;
    sts_o.wok      = wok_q;
    sts_o.full     = full;
    sts_o.empty    = empty;
    sts_o.waiting  = waiting_q;
    sts_o.due      = ({1'b0, now_q} >= deadline_q);
    sts_o.head_exp = rd_q.expects;
    sts_o.out_free = out_free;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !full)
    else $error("push into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd_head |=> (ctl_i.pop && !$past(empty)) || !ctl_i.pop)
    else $error("pop from an empty queue");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> out_free)
    else $error("emit overwrites a pending transfer");

  a_wait_cleared_on_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.flush |=> !waiting_q && count_q == '0)
    else $error("flush left state behind");
`endif

endmodule

`default_nettype wire

// ----- rtl/rsq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rsq_pkg::dp_sts_t sts_i,
  output rsq_pkg::dp_cmd_t      ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_DRAIN    = 6'b000100,
    S_READ     = 6'b001000,
    S_WRITE    = 6'b010000,
    S_COMPL    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd)
          rsq_pkg::CMD_SUBMIT: begin
            if (sts_i.out_free) begin
              ctl_o.emit      = 1'b1;
              ctl_o.emit_last = 1'b1;
              ctl_o.emit_kind = sts_i.full ? rsq_pkg::EV_REJECTED : rsq_pkg::EV_ACCEPTED;
              ctl_o.push      = !sts_i.full;
              state_d         = S_IDLE;
            end
          end
          rsq_pkg::CMD_TICK: begin
            if (sts_i.waiting && sts_i.due) begin
              if (sts_i.out_free) begin
                ctl_o.emit      = 1'b1;
                ctl_o.emit_cur  = 1'b1;
                ctl_o.emit_kind = rsq_pkg::EV_TIMED_OUT;
                ctl_o.emit_last = sts_i.empty;
                ctl_o.clr_wait  = 1'b1;
                state_d         = S_DRAIN;
              end
            end else begin
              state_d = S_DRAIN;
            end
          end
          rsq_pkg::CMD_VERDICT: begin
            if (sts_i.waiting &&
                (sts_i.ds == rsq_pkg::DS_COMPLETE || sts_i.ds == rsq_pkg::DS_ERROR)) begin
              if (sts_i.out_free) begin
                ctl_o.emit      = 1'b1;
                ctl_o.emit_cur  = 1'b1;
                ctl_o.emit_kind = (sts_i.ds == rsq_pkg::DS_COMPLETE) ?
                                  rsq_pkg::EV_COMPLETED : rsq_pkg::EV_RESP_ERROR;
                ctl_o.emit_last = sts_i.empty;
                ctl_o.clr_wait  = 1'b1;
                state_d         = S_DRAIN;
              end
            end else begin
              state_d = S_IDLE;
            end
          end
          rsq_pkg::CMD_RESET: begin
            ctl_o.flush = 1'b1;
            state_d     = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DRAIN: begin
        if (!sts_i.waiting && !sts_i.empty) begin
          ctl_o.rd_head = 1'b1;
          state_d       = S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        ctl_o.pop = 1'b1;
        state_d   = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_cur = 1'b1;
          if (!sts_i.wok) begin
            ctl_o.emit_kind = rsq_pkg::EV_WRITE_FAILED;
            ctl_o.emit_last = sts_i.empty;
            state_d         = S_DRAIN;
          end else if (sts_i.head_exp) begin
            ctl_o.emit_kind = rsq_pkg::EV_WRITTEN;
            ctl_o.emit_last = 1'b1;
            state_d         = S_DRAIN;
          end else begin
            ctl_o.emit_kind = rsq_pkg::EV_WRITTEN;
            ctl_o.emit_last = 1'b0;
            state_d         = S_COMPL;
          end
        end
      end
      S_COMPL: begin
        if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_cur  = 1'b1;
          ctl_o.emit_kind = rsq_pkg::EV_COMPLETED;
          ctl_o.emit_last = sts_i.empty;
          state_d         = S_DRAIN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/request_sequencer_with_timeout_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer with response timeout. Submits (tuser 0) queue a request
// in a QUEUE_DEPTH-entry FIFO and always answer with one event, accepted or
// rejected full. Ticks (tuser 1) first time out the in-flight request once
// now reaches its deadline; verdicts (tuser 2) end it as completed or error;
// ticks, and verdicts that end it, then drain the FIFO, writing each
// request out until one that expects an answer is written successfully, which
// arms deadline = now + timeout. Reset commands (tuser 3) empty the FIFO and
// drop the in-flight request. Every event is one master-side transfer; tlast
// marks the final event of an input item, and items that cause no event
// produce no transfer. Timing: the input is taken in the idle state only.
// Each drained request passes through the registered read of the queue
// memory and the single output register, and output back-pressure holds
// the controller in its state until the output register is free. There is
// no clearing pass after reset. timeout_seconds sits at APB byte address 0.

module request_sequencer_with_timeout_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now, [63:32] req_uid, [65:64] req_kind, [66] req_expects_response,
  // [67] write_ok, [69:68] data_status, [71:70] zero
  input  wire logic [71:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  // Events
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] event_uid, [33:32] event_req_kind, [39:34] zero
  output logic [39:0]      m_axis_tdata,
  // [2:0] event_kind
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rsq_pkg::dp_cmd_t ctl;
  rsq_pkg::dp_sts_t sts;

  logic [7:0]  timeout_q;
  logic [31:0] ev_uid;
  logic [1:0]  ev_req_kind;

  // Timeout register: written in the APB access phase, always ready.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rsq_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == rsq_pkg::REG_TIMEOUT) begin
      timeout_q <= pwdata[7:0];
    end
  end

  // Return the register at its address, zero elsewhere.
  assign prdata = (paddr[2] == rsq_pkg::REG_TIMEOUT) ? {24'b0, timeout_q} : 32'b0;

  rsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rsq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (s_axis_tuser),
    .now_i          (s_axis_tdata[31:0]),
    .uid_i          (s_axis_tdata[63:32]),
    .kind_i         (s_axis_tdata[65:64]),
    .exp_i          (s_axis_tdata[66]),
    .wok_i          (s_axis_tdata[67]),
    .ds_i           (s_axis_tdata[69:68]),
    .timeout_i      (timeout_q),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_kind_o     (m_axis_tuser),
    .out_uid_o      (ev_uid),
    .out_req_kind_o (ev_req_kind),
    .out_last_o     (m_axis_tlast)
  );

  // Pack the event payload, padding to whole bytes.
  assign m_axis_tdata = {6'b0, ev_req_kind, ev_uid};

endmodule

`default_nettype wire
